[hdl/crcfst_pkg.sv]
// shared types and constants for the crc framed serial transmitter
package crcfst_pkg;

	// frame length register
	localparam logic [7:0] FRAME_LEN_RESET = 8'd28;
	localparam logic [7:0] FRAME_LEN_MIN   = 8'd3;

	// wire constants
	localparam logic [7:0]  PREAMBLE_MARK = 8'h51;
	localparam logic [15:0] CRC_POLY      = 16'hA001;

	// command queue between front and serializer
	localparam int CMD_DEPTH = 2;
	localparam int CMD_PTR_W = (CMD_DEPTH > 1) ? $clog2(CMD_DEPTH) : 1;
	localparam int CMD_CNT_W = $clog2(CMD_DEPTH + 1);

	// one classified payload word and what goes around it on the wire
	typedef struct packed {
		logic        pre;    // preamble goes first
		logic        close;  // crc bytes follow, frame ends
		logic [7:0]  data;
		logic [7:0]  len;    // effective frame length for the preamble
		logic [15:0] crc;    // crc including this word
	} cmd_t;

	// wire byte being shifted out
	typedef enum logic [2:0] {
		STEP_LEN_A,
		STEP_MARK,
		STEP_LEN_B,
		STEP_DATA,
		STEP_CRC_LO,
		STEP_CRC_HI
	} step_t;

endpackage

[hdl/crcfst_front.sv]
// front end: frame tracking, crc update and word classification
module crcfst_front (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [7:0]       cfg_data,
	input  logic             accept,
	input  logic [7:0]       payload_byte,
	output crcfst_pkg::cmd_t cmd
);

	logic [7:0]  frame_len_q;
	logic        in_frame_q;
	logic [7:0]  count_q;
	logic [15:0] crc_q;

	logic [7:0]  eff_len;
	logic [7:0]  plen;
	logic [7:0]  cnt_base;
	logic [15:0] crc_base;
	logic [7:0]  new_cnt;
	logic [15:0] new_crc;
	logic        close;

	// reflected crc over one byte, one bit per step
	function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] d);
		logic [15:0] c;
		c = crc ^ {8'd0, d};
		for (int i = 0; i < 8; i++) begin
			if (c[0]) begin
				c = (c >> 1) ^ crcfst_pkg::CRC_POLY;
			end else begin
				c = c >> 1;
			end
		end
		return c;
	endfunction

	// classify the incoming word
	always_comb begin
		eff_len  = (frame_len_q < crcfst_pkg::FRAME_LEN_MIN) ? crcfst_pkg::FRAME_LEN_MIN
		                                                     : frame_len_q;
		plen     = eff_len - 8'd2;
		cnt_base = in_frame_q ? count_q : 8'd0;
		crc_base = in_frame_q ? crc_q : 16'd0;
		new_cnt  = (cnt_base == 8'hFF) ? 8'hFF : cnt_base + 8'd1;
		new_crc  = crc_byte(crc_base, payload_byte);
		close    = (new_cnt >= plen);

		cmd.pre   = !in_frame_q;
		cmd.close = close;
		cmd.data  = payload_byte;
		cmd.len   = eff_len;
		cmd.crc   = new_crc;
	end

	// frame length register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_len_q <= crcfst_pkg::FRAME_LEN_RESET;
		end else if (cfg_we) begin
			frame_len_q <= cfg_data;
		end
	end

	// frame state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_frame_q <= 1'b0;
			count_q    <= 8'd0;
			crc_q      <= 16'd0;
		end else if (accept) begin
			in_frame_q <= !close;
			count_q    <= close ? 8'd0 : new_cnt;
			crc_q      <= close ? 16'd0 : new_crc;
		end
	end

endmodule

[hdl/crcfst_cmd_queue.sv]
// short command queue between the front end and the serializer
module crcfst_cmd_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_en,
	input  crcfst_pkg::cmd_t wr_data,
	input  logic             rd_en,
	output crcfst_pkg::cmd_t rd_data,
	output logic             full,
	output logic             empty
);

	localparam logic [crcfst_pkg::CMD_PTR_W-1:0] PTR_LAST =
		crcfst_pkg::CMD_PTR_W'(crcfst_pkg::CMD_DEPTH - 1);
	localparam logic [crcfst_pkg::CMD_CNT_W-1:0] CNT_FULL =
		crcfst_pkg::CMD_CNT_W'(crcfst_pkg::CMD_DEPTH);

	crcfst_pkg::cmd_t                 slot_q [crcfst_pkg::CMD_DEPTH];
	logic [crcfst_pkg::CMD_PTR_W-1:0] wr_ptr_q;
	logic [crcfst_pkg::CMD_PTR_W-1:0] rd_ptr_q;
	logic [crcfst_pkg::CMD_CNT_W-1:0] count_q;
	logic                             do_wr;
	logic                             do_rd;

	assign full    = (count_q == CNT_FULL);
	assign empty   = (count_q == '0);
	assign do_wr   = wr_en && !full;
	assign do_rd   = rd_en && !empty;
	assign rd_data = slot_q[rd_ptr_q];

	// storage
	always_ff @(posedge clk) begin
		if (do_wr) begin
			slot_q[wr_ptr_q] <= wr_data;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

[hdl/crcfst_serializer.sv]
// back end: turns commands into wire bits, one per cycle while pop is held, with an output register
module crcfst_serializer (
	input  logic             clk,
	input  logic             arst_n,
	input  crcfst_pkg::cmd_t q_data,
	input  logic             q_empty,
	output logic             q_pop,
	input  logic             pop,
	output logic             empty,
	output logic             data_pin,
	output logic             select_pulse,
	output logic             frame_end,
	output logic             run_last
);

	crcfst_pkg::cmd_t   cmd_q;
	logic               busy_q;
	crcfst_pkg::step_t  step_q;
	crcfst_pkg::step_t  step_next;
	logic [2:0]         bit_q;

	logic               out_valid_q;
	logic               data_pin_q;
	logic               select_q;
	logic               frame_end_q;
	logic               run_last_q;

	logic               advance;
	logic               last_step;
	logic               last_bit;
	logic [7:0]         byte_v;
	logic               bit_v;
	logic               load;

	assign advance = !out_valid_q || pop;
	assign last_bit = (bit_q == 3'd7) && last_step;
	assign load    = !busy_q || (advance && last_bit);
	assign q_pop   = load && !q_empty;

	// next wire byte
	always_comb begin
		unique case (step_q)
			crcfst_pkg::STEP_LEN_A:  step_next = crcfst_pkg::STEP_MARK;
			crcfst_pkg::STEP_MARK:   step_next = crcfst_pkg::STEP_LEN_B;
			crcfst_pkg::STEP_LEN_B:  step_next = crcfst_pkg::STEP_DATA;
			crcfst_pkg::STEP_DATA:   step_next = crcfst_pkg::STEP_CRC_LO;
			crcfst_pkg::STEP_CRC_LO: step_next = crcfst_pkg::STEP_CRC_HI;
			default:                 step_next = crcfst_pkg::STEP_CRC_HI;
		endcase
	end

	// byte contents and bit pick
	always_comb begin
		unique case (step_q)
			crcfst_pkg::STEP_LEN_A:  byte_v = cmd_q.len;
			crcfst_pkg::STEP_MARK:   byte_v = crcfst_pkg::PREAMBLE_MARK;
			crcfst_pkg::STEP_LEN_B:  byte_v = cmd_q.len;
			crcfst_pkg::STEP_DATA:   byte_v = cmd_q.data;
			crcfst_pkg::STEP_CRC_LO: byte_v = cmd_q.crc[7:0];
			default:                 byte_v = cmd_q.crc[15:8];
		endcase
		bit_v     = byte_v[3'd7 - bit_q];
		last_step = (step_q == crcfst_pkg::STEP_CRC_HI) ||
		            ((step_q == crcfst_pkg::STEP_DATA) && !cmd_q.close);
	end

	// command register and bit position
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			step_q <= crcfst_pkg::STEP_DATA;
			bit_q  <= 3'd0;
		end else if (q_pop) begin
			busy_q <= 1'b1;
			step_q <= q_data.pre ? crcfst_pkg::STEP_LEN_A : crcfst_pkg::STEP_DATA;
			bit_q  <= 3'd0;
		end else if (busy_q && advance) begin
			if (last_bit) begin
				busy_q <= 1'b0;
			end else begin
				bit_q <= bit_q + 3'd1;
				if (bit_q == 3'd7) begin
					step_q <= step_next;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			cmd_q <= q_data;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= busy_q;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			data_pin_q  <= !bit_v;
			select_q    <= (bit_q == 3'd0);
			frame_end_q <= (step_q == crcfst_pkg::STEP_CRC_HI) && (bit_q == 3'd7);
			run_last_q  <= last_bit;
		end
	end

	assign empty        = !out_valid_q;
	assign data_pin     = data_pin_q;
	assign select_pulse = select_q;
	assign frame_end    = frame_end_q;
	assign run_last     = run_last_q;

	// frame end is always the last bit of its word
	a_end_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && frame_end_q |-> run_last_q)
		else $error("frame end without word end");

	// crc bytes only for a closing word
	a_crc_needs_close: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q && (step_q == crcfst_pkg::STEP_CRC_LO || step_q == crcfst_pkg::STEP_CRC_HI)
		|-> cmd_q.close)
		else $error("crc byte sent for a word that does not close the frame");

	// preamble bytes only for a frame's first word
	a_pre_needs_flag: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q && (step_q == crcfst_pkg::STEP_LEN_A || step_q == crcfst_pkg::STEP_MARK ||
		           step_q == crcfst_pkg::STEP_LEN_B)
		|-> cmd_q.pre)
		else $error("preamble byte sent for a word inside a frame");

	// a stalled output does not drop or change
	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !pop |=> out_valid_q && $stable(run_last_q) && $stable(data_pin_q))
		else $error("stalled result changed");

endmodule

[hdl/crc_framed_serial_transmitter.sv]
// top level of the crc framed serial transmitter
// Each accepted payload word leaves as serial wire bits, one result per clock while pop
// is held: 8 results for a word inside a frame, 32 for the first word of a frame (three
// preamble bytes ahead of it), 24 for the word that closes the frame (crc low then high
// byte after it), and 48 when one word is the whole payload. The serializer, shifting one
// bit a cycle while pop is held, sets the rate at which words are taken inside a frame. A
// two-word command queue lets the front end take words ahead of the serializer; when the
// serializer has run dry, a taken word passes through the command queue, the serializer's
// command register and the output register before its first bit reaches the result ports.
// frame_length is written through cfg_we/cfg_data while the block is idle;
// values below 3 act as 3.
module crc_framed_serial_transmitter (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic [7:0] cfg_data,
	input  logic       push,
	output logic       full,
	input  logic [7:0] payload_byte,
	output logic       empty,
	input  logic       pop,
	output logic       data_pin,
	output logic       select_pulse,
	output logic       frame_end,
	output logic       run_last
);

	crcfst_pkg::cmd_t front_cmd;
	crcfst_pkg::cmd_t head_cmd;
	logic             accept;
	logic             q_pop;
	logic             q_empty;

	assign accept = push && !full;

	// front end
	crcfst_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_data     (cfg_data),
		.accept       (accept),
		.payload_byte (payload_byte),
		.cmd          (front_cmd)
	);

	// command queue
	crcfst_cmd_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (accept),
		.wr_data (front_cmd),
		.rd_en   (q_pop),
		.rd_data (head_cmd),
		.full    (full),
		.empty   (q_empty)
	);

	// serializer
	crcfst_serializer u_ser (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_data       (head_cmd),
		.q_empty      (q_empty),
		.q_pop        (q_pop),
		.pop          (pop),
		.empty        (empty),
		.data_pin     (data_pin),
		.select_pulse (select_pulse),
		.frame_end    (frame_end),
		.run_last     (run_last)
	);

endmodule

[dv/crcfst_wire_checker.sv]
// checker for the crc framed serial transmitter: predicts wire bits and compares them
`timescale 1ns / 1ps

module crcfst_wire_checker (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic [7:0] cfg_data,
	input  logic       push,
	input  logic       full,
	input  logic [7:0] payload_byte,
	input  logic       empty,
	input  logic       pop,
	input  logic       data_pin,
	input  logic       select_pulse,
	input  logic       frame_end,
	input  logic       run_last,
	output int         fail_count,
	output int         bits_pending,
	output int         bits_checked,
	output int         frames_closed
);

	// one expected wire bit, same field order as the result ports
	typedef struct packed {
		logic pin;
		logic sel;
		logic fend;
		logic rlast;
	} wire_bit_t;

	wire_bit_t   wire_bits_due[$];
	wire_bit_t   want_bit;
	wire_bit_t   got_bit;

	// predictor copy of the block state
	logic [7:0]  frame_len_q;
	logic [15:0] crc_run;
	logic [7:0]  words_taken;
	logic        framing;

	// crc-16/arc over one byte, reflected
	function automatic logic [15:0] crc16_arc_byte(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {8'h00, b};
		for (int i = 0; i < 8; i++) begin
			c = c[0] ? ((c >> 1) ^ crcfst_pkg::CRC_POLY) : (c >> 1);
		end
		return c;
	endfunction

	// one wire byte, msb first, pin inverted, select on the first bit
	task automatic queue_wire_byte(input logic [7:0] b, input logic closes);
		wire_bit_t e;
		for (int i = 0; i < 8; i++) begin
			e.pin   = ~b[7 - i];
			e.sel   = (i == 0);
			e.fend  = closes && (i == 7);
			e.rlast = 1'b0;
			wire_bits_due.push_back(e);
		end
	endtask

	// all wire bits caused by one accepted payload word
	task automatic predict_wire_bits(input logic [7:0] b);
		logic [7:0] eff_len;
		logic [7:0] pay_len;
		wire_bit_t  tail;
		eff_len = (frame_len_q < crcfst_pkg::FRAME_LEN_MIN) ? crcfst_pkg::FRAME_LEN_MIN
		                                                    : frame_len_q;
		pay_len = eff_len - 8'd2;
		// preamble opens a frame
		if (!framing) begin
			queue_wire_byte(eff_len, 1'b0);
			queue_wire_byte(crcfst_pkg::PREAMBLE_MARK, 1'b0);
			queue_wire_byte(eff_len, 1'b0);
			framing     = 1'b1;
			crc_run     = '0;
			words_taken = '0;
		end
		queue_wire_byte(b, 1'b0);
		crc_run = crc16_arc_byte(crc_run, b);
		if (words_taken != 8'hFF)
			words_taken = words_taken + 8'd1;
		// crc trailer closes the frame, low byte first
		if (words_taken >= pay_len) begin
			queue_wire_byte(crc_run[7:0], 1'b0);
			queue_wire_byte(crc_run[15:8], 1'b1);
			framing     = 1'b0;
			words_taken = '0;
			crc_run     = '0;
			frames_closed++;
		end
		tail = wire_bits_due.pop_back();
		tail.rlast = 1'b1;
		wire_bits_due.push_back(tail);
	endtask

	// watch both channels at the rising edge
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wire_bits_due.delete();
			frame_len_q   = crcfst_pkg::FRAME_LEN_RESET;
			crc_run       = '0;
			words_taken   = '0;
			framing       = 1'b0;
			fail_count    = 0;
			bits_checked  = 0;
			frames_closed = 0;
			bits_pending  = 0;
		end else begin
			// compare the result word first so a same-edge push cannot mask it
			if (pop && !empty) begin
				got_bit = {data_pin, select_pulse, frame_end, run_last};
				if (wire_bits_due.size() == 0) begin
					if (fail_count < 10)
						$display("%0t: unexpected result word pin=%b sel=%b end=%b last=%b",
							$realtime, got_bit.pin, got_bit.sel, got_bit.fend, got_bit.rlast);
					fail_count++;
				end else begin
					want_bit = wire_bits_due.pop_front();
					if (got_bit !== want_bit) begin
						if (fail_count < 10)
							$display("%0t: bit %0d expected %b%b%b%b actual %b%b%b%b",
								$realtime, bits_checked,
								want_bit.pin, want_bit.sel, want_bit.fend, want_bit.rlast,
								got_bit.pin, got_bit.sel, got_bit.fend, got_bit.rlast);
						fail_count++;
					end
					bits_checked++;
				end
			end
			if (cfg_we)
				frame_len_q = cfg_data;
			if (push && !full)
				predict_wire_bits(payload_byte);
			bits_pending = wire_bits_due.size();
		end
	end

endmodule

[dv/testbench.sv]
// top of the crc framed serial transmitter testbench: stimulus, pressure and verdict
`timescale 1ns / 1ps

module testbench;

	localparam int CYCLE_LIMIT  = 1000000;
	localparam int RAND_PHASES  = 12;
	localparam int PHASE_WORDS  = 25;
	localparam int LONG_HOLD    = 250;

	logic       clk;
	logic       arst_n;
	logic       cfg_we;
	logic [7:0] cfg_data;
	logic       push;
	logic       full;
	logic [7:0] payload_byte;
	logic       empty;
	logic       pop;
	logic       data_pin;
	logic       select_pulse;
	logic       frame_end;
	logic       run_last;

	int fail_count;
	int bits_pending;
	int bits_checked;
	int frames_closed;
	int cycle_count;
	int words_sent;
	int lengths_used;
	int hold_left;
	int gap_left;
	bit quiet;
	bit long_hold_req;
	bit hold_taken;

	crc_framed_serial_transmitter DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_data     (cfg_data),
		.push         (push),
		.full         (full),
		.payload_byte (payload_byte),
		.empty        (empty),
		.pop          (pop),
		.data_pin     (data_pin),
		.select_pulse (select_pulse),
		.frame_end    (frame_end),
		.run_last     (run_last)
	);

	crcfst_wire_checker checker_i (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_data      (cfg_data),
		.push          (push),
		.full          (full),
		.payload_byte  (payload_byte),
		.empty         (empty),
		.pop           (pop),
		.data_pin      (data_pin),
		.select_pulse  (select_pulse),
		.frame_end     (frame_end),
		.run_last      (run_last),
		.fail_count    (fail_count),
		.bits_pending  (bits_pending),
		.bits_checked  (bits_checked),
		.frames_closed (frames_closed)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// run limit
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("crc_framed_serial_transmitter verification failed");
			$finish;
		end
	end

	// receiver: random stall bursts, one long hold to fill the block
	initial begin
		pop        = 1'b0;
		hold_left  = 0;
		gap_left   = 0;
		hold_taken = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (long_hold_req && !hold_taken) begin
				hold_taken = 1'b1;
				hold_left  = LONG_HOLD;
			end
			if (hold_left > 0) begin
				hold_left--;
				pop <= 1'b0;
			end else if (gap_left > 0) begin
				gap_left--;
				pop <= 1'b0;
			end else if (!quiet && $urandom_range(0, 7) == 0) begin
				gap_left = $urandom_range(1, 12) - 1;
				pop <= 1'b0;
			end else begin
				pop <= 1'b1;
			end
		end
	end

	// offer one payload word and wait until it is taken
	task automatic send_word(input logic [7:0] b);
		if (!quiet && $urandom_range(0, 5) == 0) begin
			@(negedge clk);
			push <= 1'b0;
			repeat ($urandom_range(1, 12) - 1) @(negedge clk);
		end
		@(negedge clk);
		push         <= 1'b1;
		payload_byte <= b;
		do @(posedge clk); while (full);
		words_sent++;
	endtask

	// write the frame length once the block has drained
	task automatic set_length(input logic [7:0] len);
		@(negedge clk);
		push <= 1'b0;
		wait (bits_pending == 0);
		@(negedge clk);
		cfg_we   <= 1'b1;
		cfg_data <= len;
		@(negedge clk);
		cfg_we <= 1'b0;
		lengths_used++;
	endtask

	// stimulus and verdict
	initial begin
		logic [7:0] len;
		arst_n        = 1'b0;
		cfg_we        = 1'b0;
		cfg_data      = 8'h00;
		push          = 1'b0;
		payload_byte  = 8'h00;
		quiet         = 1'b0;
		long_hold_req = 1'b0;
		words_sent    = 0;
		lengths_used  = 0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// reset length, frame left open, then shortened below what was taken
		send_word(8'h00);
		send_word(8'hFF);
		set_length(8'd0);
		send_word(8'h3C);
		// lengths below the minimum give single word frames
		send_word(8'hA5);
		set_length(8'd1);
		send_word(8'h5A);
		set_length(8'd2);
		send_word(8'h01);
		set_length(8'd3);
		send_word(8'h80);
		send_word(8'h7E);
		set_length(8'd4);
		send_word(8'hFF);
		send_word(8'h00);
		// shortened to exactly the words already taken
		set_length(8'd10);
		send_word(8'h12);
		send_word(8'h34);
		send_word(8'h56);
		set_length(8'd5);
		send_word(8'h78);
		// longest length, then cut back mid-frame without closing at once
		set_length(8'd255);
		send_word(8'hC3);
		send_word(8'h99);
		set_length(8'd6);
		send_word(8'hAA);
		send_word(8'h55);

		// random phases, mostly short frames, at least one long frame, a quiet phase and a quiet tail
		for (int ph = 0; ph < RAND_PHASES; ph++) begin
			if (ph == 0)
				len = 8'd255;
			else if (ph == 1)
				len = 8'd0;
			else if ($urandom_range(0, 3) == 0)
				len = 8'($urandom_range(0, 255));
			else
				len = 8'($urandom_range(0, 12));
			set_length(len);
			quiet = (ph == 5) || (ph == RAND_PHASES - 1);
			if (ph == 3) begin
				@(posedge clk);
				long_hold_req = 1'b1;
			end
			for (int w = 0; w < PHASE_WORDS; w++)
				send_word(8'($urandom_range(0, 255)));
		end

		// drain
		@(negedge clk);
		push <= 1'b0;
		wait (bits_pending == 0);
		repeat (20) @(posedge clk);

		$display("covered %0d payload words over %0d frame length settings (0, 3, 255 among them)",
			words_sent, lengths_used);
		$display("checked %0d wire bits in %0d closed frames", bits_checked, frames_closed);
		if (fail_count == 0 && bits_pending == 0) begin
			$display("crc_framed_serial_transmitter verification clean");
		end else begin
			$display("crc_framed_serial_transmitter verification failed");
		end
		$finish;
	end

endmodule
